// ----- sv/afhc_pkg.sv -----
// Shared widths, codes and constants for the async HDLC frame checker.
package afhc_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 12;
  localparam int MAP_W    = 32;
  localparam int CRC_W    = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MAP_W;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;
  localparam logic [BYTE_W-1:0] CTRL_LIM  = 8'h20;
  localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_GOOD  = 16'hF0B8;
  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h8408;
  localparam int                MIN_FRAME = 4;

  localparam logic [LEN_W-1:0]  MAX_LEN_RST = 12'd1500;
  localparam logic [MAP_W-1:0]  MAP_RST     = 32'h0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FRAME_LEN = 1'b0,
    CFG_RX_CHAR_MAP   = 1'b1
  } afhc_cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GOOD     = 3'd0,
    ST_UNSYNCED = 3'd1,
    ST_OVERLONG = 3'd2,
    ST_ABORTED  = 3'd3,
    ST_SHORT    = 3'd4,
    ST_BADCHECK = 3'd5
  } afhc_status_t;

endpackage

// ----- sv/afhc_in_if.sv -----
// Received byte channel: valid/ready with raw byte and buffer-end marker.
interface afhc_in_if;
  logic                        valid;
  logic                        ready;
  logic [afhc_pkg::BYTE_W-1:0] rx_byte;
  logic                        last_in_buffer;

  modport source(output valid, rx_byte, last_in_buffer, input ready);
  modport sink(input valid, rx_byte, last_in_buffer, output ready);
endinterface

// ----- sv/afhc_out_if.sv -----
// Result channel: valid/ready with per-byte frame and buffer report.
interface afhc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          frame_end;
  logic                          frame_good;
  logic [afhc_pkg::STATUS_W-1:0] frame_status;
  logic [afhc_pkg::LEN_W-1:0]    frame_length;
  logic                          buffer_done;
  logic                          buffer_had_good;

  modport source(output valid, frame_end, frame_good, frame_status, frame_length,
                 buffer_done, buffer_had_good, input ready);
  modport sink(input valid, frame_end, frame_good, frame_status, frame_length,
               buffer_done, buffer_had_good, output ready);
endinterface

// ----- sv/async_hdlc_frame_checker.sv -----
// Top level of the async HDLC frame checker.
// Takes one received byte request per clock and returns one result per byte, passing it
// through the input register and then the result register. Unescaping, the receive
// map filter, one byte-wide FCS-16 step and the frame counters all sit in the single
// logic stage between those registers, so a byte can be accepted every cycle; while a
// finished result waits to be taken the input register holds the next byte, and the
// input stalls once that register is full too.
// No clearing pass after reset. Configuration is written through the cfg_ port.
module async_hdlc_frame_checker #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [afhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afhc_pkg::CFG_DATA_W-1:0] cfg_data,
  afhc_in_if.sink                         in_chan,
  afhc_out_if.source                      out_chan
);

  afhc_in_if mid_chan ();

  afhc_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (in_chan),
    .dn    (mid_chan)
  );

  afhc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (mid_chan),
    .out_chan  (out_chan)
  );

endmodule

// ----- sv/afhc_in_reg.sv -----
// Input register stage: captures one received byte request per cycle while empty or downstream is ready.
module afhc_in_reg (
  input  logic         clk,
  input  logic         rst_n,
  afhc_in_if.sink      up,
  afhc_in_if.source    dn
);

  logic                        valid_r;
  logic [afhc_pkg::BYTE_W-1:0] byte_r;
  logic                        last_r;

  assign up.ready         = !valid_r || dn.ready;
  assign dn.valid         = valid_r;
  assign dn.rx_byte       = byte_r;
  assign dn.last_in_buffer = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up.ready) begin
      valid_r <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      byte_r <= up.rx_byte;
      last_r <= up.last_in_buffer;
    end
  end

endmodule

// ----- sv/afhc_core.sv -----
// Deframer core: unescape, map filter, FCS-16 step, frame state and result register.
module afhc_core #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [afhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afhc_pkg::CFG_DATA_W-1:0] cfg_data,
  afhc_in_if.sink                         in_chan,
  afhc_out_if.source                      out_chan
);

  localparam int CMP_W = (COUNT_WIDTH > afhc_pkg::LEN_W) ? COUNT_WIDTH : afhc_pkg::LEN_W;
  localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((1 << COUNT_WIDTH) - 1);

  function automatic logic [afhc_pkg::CRC_W-1:0] crc_byte(
    input logic [afhc_pkg::CRC_W-1:0]  crc,
    input logic [afhc_pkg::BYTE_W-1:0] b
  );
    logic [afhc_pkg::CRC_W-1:0] c;
    c = crc ^ {{(afhc_pkg::CRC_W-afhc_pkg::BYTE_W){1'b0}}, b};
    for (int i = 0; i < afhc_pkg::BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ afhc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // configuration
  logic [afhc_pkg::LEN_W-1:0] max_len_r;
  logic [afhc_pkg::MAP_W-1:0] char_map_r;

  // frame state
  logic [afhc_pkg::CRC_W-1:0] crc_r, crc_nxt;
  logic [COUNT_WIDTH-1:0]     cnt_r, cnt_nxt;
  logic                       esc_r, esc_nxt;
  logic                       unsync_r, unsync_nxt;
  logic                       overlong_r, overlong_nxt;
  logic                       good_r, good_nxt;

  // result register
  logic                         out_valid_r;
  logic                         frame_end_r, frame_end_nxt;
  logic                         frame_good_r, frame_good_nxt;
  afhc_pkg::afhc_status_t       status_r, status_nxt;
  logic [afhc_pkg::LEN_W-1:0]   length_r, length_nxt;
  logic                         buf_done_r;
  logic                         buf_good_r, buf_good_nxt;

  logic                        fire;
  logic                        is_flag;
  logic                        dropped;
  logic [afhc_pkg::BYTE_W-1:0] data_byte;
  logic [CMP_W-1:0]            limit;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign fire          = in_chan.valid && in_chan.ready;

  assign is_flag   = (in_chan.rx_byte == afhc_pkg::FLAG_BYTE);
  assign dropped   = (in_chan.rx_byte < afhc_pkg::CTRL_LIM) && char_map_r[in_chan.rx_byte[4:0]];
  assign data_byte = in_chan.rx_byte ^ afhc_pkg::ESC_XOR;
  assign limit     = (CMP_W'(max_len_r) < CNT_MAX) ? CMP_W'(max_len_r) : CNT_MAX;

  always_comb begin
    crc_nxt        = crc_r;
    cnt_nxt        = cnt_r;
    esc_nxt        = esc_r;
    unsync_nxt     = unsync_r;
    overlong_nxt   = overlong_r;
    good_nxt       = good_r;
    frame_end_nxt  = 1'b0;
    frame_good_nxt = 1'b0;
    status_nxt     = afhc_pkg::ST_GOOD;
    length_nxt     = '0;

    if (is_flag) begin
      priority if (unsync_r)                                   status_nxt = afhc_pkg::ST_UNSYNCED;
      else if (overlong_r)                                     status_nxt = afhc_pkg::ST_OVERLONG;
      else if (esc_r)                                          status_nxt = afhc_pkg::ST_ABORTED;
      else if (cnt_r < COUNT_WIDTH'(afhc_pkg::MIN_FRAME))      status_nxt = afhc_pkg::ST_SHORT;
      else if (crc_r != afhc_pkg::CRC_GOOD)                    status_nxt = afhc_pkg::ST_BADCHECK;
      else                                                     status_nxt = afhc_pkg::ST_GOOD;
      frame_end_nxt  = 1'b1;
      frame_good_nxt = (status_nxt == afhc_pkg::ST_GOOD);
      length_nxt     = afhc_pkg::LEN_W'(cnt_r);
      good_nxt       = good_r | frame_good_nxt;
      crc_nxt        = afhc_pkg::CRC_INIT;
      cnt_nxt        = '0;
      esc_nxt        = 1'b0;
      unsync_nxt     = 1'b0;
      overlong_nxt   = 1'b0;
    end else if (!unsync_r && !overlong_r && !dropped) begin
      if (!esc_r && (in_chan.rx_byte == afhc_pkg::ESC_BYTE)) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (CMP_W'(cnt_r) < limit) begin
          cnt_nxt = cnt_r + COUNT_WIDTH'(1);
          crc_nxt = crc_byte(crc_r, esc_r ? data_byte : in_chan.rx_byte);
        end else begin
          overlong_nxt = 1'b1;
        end
      end
    end

    buf_good_nxt = in_chan.last_in_buffer && good_nxt;

    // buffer end returns the frame state to reset
    if (in_chan.last_in_buffer) begin
      crc_nxt      = afhc_pkg::CRC_INIT;
      cnt_nxt      = '0;
      esc_nxt      = 1'b0;
      unsync_nxt   = 1'b1;
      overlong_nxt = 1'b0;
      good_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= afhc_pkg::MAX_LEN_RST;
      char_map_r <= afhc_pkg::MAP_RST;
    end else if (cfg_we) begin
      unique case (afhc_pkg::afhc_cfg_idx_t'(cfg_index))
        afhc_pkg::CFG_MAX_FRAME_LEN: max_len_r  <= cfg_data[afhc_pkg::LEN_W-1:0];
        afhc_pkg::CFG_RX_CHAR_MAP:   char_map_r <= cfg_data[afhc_pkg::MAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= afhc_pkg::CRC_INIT;
      cnt_r       <= '0;
      esc_r       <= 1'b0;
      unsync_r    <= 1'b1;
      overlong_r  <= 1'b0;
      good_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        crc_r      <= crc_nxt;
        cnt_r      <= cnt_nxt;
        esc_r      <= esc_nxt;
        unsync_r   <= unsync_nxt;
        overlong_r <= overlong_nxt;
        good_r     <= good_nxt;
      end
      if (in_chan.ready) begin
        out_valid_r <= in_chan.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      frame_end_r  <= frame_end_nxt;
      frame_good_r <= frame_good_nxt;
      status_r     <= status_nxt;
      length_r     <= length_nxt;
      buf_done_r   <= in_chan.last_in_buffer;
      buf_good_r   <= buf_good_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.frame_end       = frame_end_r;
  assign out_chan.frame_good      = frame_good_r;
  assign out_chan.frame_status    = status_r;
  assign out_chan.frame_length    = length_r;
  assign out_chan.buffer_done     = buf_done_r;
  assign out_chan.buffer_had_good = buf_good_r;

  a_flag_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_flag |=> (cnt_r == '0) && !esc_r && !overlong_r)
    else $error("flag did not restart frame state");

  a_good_is_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && frame_good_r |-> frame_end_r && (status_r == afhc_pkg::ST_GOOD))
    else $error("good report without a clean frame end");

  a_discard_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (overlong_r || esc_r) |-> !unsync_r)
    else $error("frame state active while unsynced");

  a_buffer_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_chan.last_in_buffer |=> unsync_r && !good_r && (crc_r == afhc_pkg::CRC_INIT))
    else $error("buffer end did not restore reset state");

endmodule
